FILE: hw/rtl/lldq_pkg.sv
// ----------------------------------------------------------------------------
// lldq_pkg: shared types and constants
// Operation codes, result codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lldq_pkg;

   localparam int NODES_DEF    = 64;
   localparam int KEY_BITS_DEF = 32;
   localparam int FUNC_W       = 3;
   localparam int ITEM_KEY_W   = 32;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT    = 3'd0,
      FUNC_DEL_KEY   = 3'd1,
      FUNC_DEL_FIRST = 3'd2,
      FUNC_DEL_LAST  = 3'd3,
      FUNC_DUMP      = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_MISS  = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_ENTRY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_POP,
      S_INS_WR,
      S_WALK_RD,
      S_WALK_CMP,
      S_END_RD,
      S_UNLINK,
      S_DUMP_RD,
      S_DUMP_EMIT
   } state_type;

   typedef struct packed {
      logic       load;      // capture request, start walk at front
      logic       stk_rd;    // read top of free stack
      logic       ins;       // link new node at front
      logic       node_rd;   // read node at walk pointer
      logic       end_rd;    // read node at front or back end
      logic       adv;       // step walk pointer to next
      logic       unlink;    // unlink last node read
      logic       emit;      // load a result
      status_type emit_status;
      logic       emit_key;  // result carries node key
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic hit;
      logic tail;
   } stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lldq_ctrl.sv
// ----------------------------------------------------------------------------
// lldq_ctrl: operation sequencer
// Steps each operation through its memory reads, walk and writes.
// ----------------------------------------------------------------------------
`default_nettype none

module lldq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [2:0]          func,
   input  wire lldq_pkg::stat_type  stat,
   output logic                     busy,
   output lldq_pkg::cmd_type        cmd
);

   lldq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lldq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lldq_pkg::S_IDLE: begin
            if (start) begin
               case (func)
                  lldq_pkg::FUNC_INSERT:
                     state_in = stat.full ? lldq_pkg::S_IDLE : lldq_pkg::S_INS_POP;
                  lldq_pkg::FUNC_DEL_KEY:
                     state_in = stat.empty ? lldq_pkg::S_IDLE : lldq_pkg::S_WALK_RD;
                  lldq_pkg::FUNC_DEL_FIRST, lldq_pkg::FUNC_DEL_LAST:
                     state_in = stat.empty ? lldq_pkg::S_IDLE : lldq_pkg::S_END_RD;
                  lldq_pkg::FUNC_DUMP:
                     state_in = stat.empty ? lldq_pkg::S_IDLE : lldq_pkg::S_DUMP_RD;
                  default: state_in = lldq_pkg::S_IDLE;
               endcase
            end
         end
         lldq_pkg::S_INS_POP:  state_in = lldq_pkg::S_INS_WR;
         lldq_pkg::S_INS_WR:   state_in = lldq_pkg::S_IDLE;
         lldq_pkg::S_WALK_RD:  state_in = lldq_pkg::S_WALK_CMP;
         lldq_pkg::S_WALK_CMP: begin
            if (stat.hit) state_in = lldq_pkg::S_UNLINK;
            else if (stat.tail) state_in = lldq_pkg::S_IDLE;
            else state_in = lldq_pkg::S_WALK_RD;
         end
         lldq_pkg::S_END_RD:   state_in = lldq_pkg::S_UNLINK;
         lldq_pkg::S_UNLINK:   state_in = lldq_pkg::S_IDLE;
         lldq_pkg::S_DUMP_RD:  state_in = lldq_pkg::S_DUMP_EMIT;
         lldq_pkg::S_DUMP_EMIT:
            state_in = stat.tail ? lldq_pkg::S_IDLE : lldq_pkg::S_DUMP_RD;
         default: state_in = lldq_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.emit_status = lldq_pkg::STAT_DONE;
      busy = (state_ff != lldq_pkg::S_IDLE);
      case (state_ff)
         lldq_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (func)
                  lldq_pkg::FUNC_INSERT: begin
                     cmd.emit = stat.full;
                     cmd.emit_status = lldq_pkg::STAT_FULL;
                  end
                  lldq_pkg::FUNC_DEL_KEY, lldq_pkg::FUNC_DEL_FIRST,
                  lldq_pkg::FUNC_DEL_LAST, lldq_pkg::FUNC_DUMP: begin
                     cmd.emit = stat.empty;
                     cmd.emit_status = lldq_pkg::STAT_MISS;
                  end
                  default: begin
                     cmd.emit = 1'b1;
                     cmd.emit_status = lldq_pkg::STAT_MISS;
                  end
               endcase
            end
         end
         lldq_pkg::S_INS_POP: cmd.stk_rd = 1'b1;
         lldq_pkg::S_INS_WR: begin
            cmd.ins = 1'b1;
            cmd.emit = 1'b1;
         end
         lldq_pkg::S_WALK_RD: cmd.node_rd = 1'b1;
         lldq_pkg::S_WALK_CMP: begin
            if (!stat.hit) begin
               if (stat.tail) begin
                  cmd.emit = 1'b1;
                  cmd.emit_status = lldq_pkg::STAT_MISS;
               end else begin
                  cmd.adv = 1'b1;
               end
            end
         end
         lldq_pkg::S_END_RD: cmd.end_rd = 1'b1;
         lldq_pkg::S_UNLINK: begin
            cmd.unlink = 1'b1;
            cmd.emit = 1'b1;
         end
         lldq_pkg::S_DUMP_RD: cmd.node_rd = 1'b1;
         lldq_pkg::S_DUMP_EMIT: begin
            cmd.emit = 1'b1;
            cmd.emit_status = lldq_pkg::STAT_ENTRY;
            cmd.emit_key = 1'b1;
            cmd.adv = !stat.tail;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lldq_dp.sv
// ----------------------------------------------------------------------------
// lldq_dp: list datapath
// Node key and link memories, free stack, end pointers, count and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lldq_dp #(
   parameter int NODES    = lldq_pkg::NODES_DEF,
   parameter int KEY_BITS = lldq_pkg::KEY_BITS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic [lldq_pkg::FUNC_W-1:0]              req_func,
   input  wire logic signed [lldq_pkg::ITEM_KEY_W-1:0]   req_item_key,
   input  wire lldq_pkg::cmd_type                        cmd,
   output lldq_pkg::stat_type                            stat,
   output logic                                          rsp_valid,
   output logic signed [lldq_pkg::ITEM_KEY_W-1:0]        rsp_out_key,
   output logic [lldq_pkg::STATUS_W-1:0]                 rsp_status,
   output logic                                          rsp_last_of_run,
   output logic [lldq_pkg::COUNT_W-1:0]                  rsp_entry_count
);

   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);

   logic [KEY_BITS-1:0] key_mem  [NODES];
   logic [IDX_W-1:0]    next_mem [NODES];
   logic [IDX_W-1:0]    prev_mem [NODES];
   logic [IDX_W-1:0]    stk_mem  [NODES];

   logic [KEY_BITS-1:0] key_q;
   logic [IDX_W-1:0]    next_q, prev_q, stk_q;

   logic [lldq_pkg::FUNC_W-1:0] func_ff;
   logic [KEY_BITS-1:0]         key_ff;
   logic [IDX_W-1:0]            cur_ff, cur_in;
   logic [IDX_W-1:0]            rd_addr_ff;
   logic [CNT_W-1:0]            step_ff, step_in;
   logic [IDX_W-1:0]            front_ff, front_in, back_ff, back_in;
   logic [CNT_W-1:0]            used_ff, used_in, sp_ff, sp_in, fresh_ff, fresh_in;

   logic                        rsp_valid_ff;
   logic [lldq_pkg::ITEM_KEY_W-1:0] rsp_key_ff;
   logic [lldq_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic                        rsp_last_ff;
   logic [lldq_pkg::COUNT_W-1:0] rsp_count_ff;

   logic [IDX_W-1:0] rd_addr, new_node, t_node;
   logic [IDX_W-1:0] sp_top;
   logic             next_we, prev_we;
   logic [IDX_W-1:0] next_wa, next_wd, prev_wa, prev_wd;

   assign sp_top = IDX_W'(sp_ff - CNT_W'(1));
   assign t_node = rd_addr_ff;

   always_comb begin
      if (cmd.end_rd)
         rd_addr = (func_ff == lldq_pkg::FUNC_DEL_LAST) ? back_ff : front_ff;
      else
         rd_addr = cur_ff;
   end

   assign new_node = (sp_ff != '0) ? stk_q : IDX_W'(fresh_ff);

   // link memory write ports
   always_comb begin
      next_we = 1'b0;
      next_wa = new_node;
      next_wd = front_ff;
      prev_we = 1'b0;
      prev_wa = front_ff;
      prev_wd = new_node;
      if (cmd.ins) begin
         next_we = 1'b1;
         prev_we = (used_ff != '0);
      end else if (cmd.unlink) begin
         next_we = (t_node != front_ff);
         next_wa = prev_q;
         next_wd = next_q;
         prev_we = (t_node != back_ff);
         prev_wa = next_q;
         prev_wd = prev_q;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins) key_mem[new_node] <= key_ff;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (cmd.unlink) stk_mem[sp_ff[IDX_W-1:0]] <= t_node;
      if (cmd.node_rd || cmd.end_rd) begin
         key_q      <= key_mem[rd_addr];
         next_q     <= next_mem[rd_addr];
         prev_q     <= prev_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (cmd.stk_rd) stk_q <= stk_mem[sp_top];
   end

   // list bookkeeping
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      used_in  = used_ff;
      sp_in    = sp_ff;
      fresh_in = fresh_ff;
      cur_in   = cur_ff;
      step_in  = step_ff;
      if (cmd.load) begin
         cur_in  = front_ff;
         step_in = '0;
      end
      if (cmd.adv) begin
         cur_in  = next_q;
         step_in = step_ff + CNT_W'(1);
      end
      if (cmd.ins) begin
         if (sp_ff != '0) sp_in = sp_ff - CNT_W'(1);
         else fresh_in = fresh_ff + CNT_W'(1);
         if (used_ff == '0) back_in = new_node;
         front_in = new_node;
         used_in  = used_ff + CNT_W'(1);
      end
      if (cmd.unlink) begin
         if (t_node == front_ff) front_in = next_q;
         if (t_node == back_ff) back_in = prev_q;
         sp_in   = sp_ff + CNT_W'(1);
         used_in = used_ff - CNT_W'(1);
         if (used_in == '0) begin
            front_in = '0;
            back_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         used_ff      <= '0;
         sp_ff        <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         used_ff      <= used_in;
         sp_ff        <= sp_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      step_ff <= step_in;
      if (cmd.load) begin
         func_ff <= req_func;
         key_ff  <= KEY_BITS'($unsigned(req_item_key));
      end
      if (cmd.emit) begin
         rsp_key_ff    <= cmd.emit_key ? lldq_pkg::ITEM_KEY_W'($unsigned(key_q)) : '0;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_key ? stat.tail : 1'b1;
         rsp_count_ff  <= lldq_pkg::COUNT_W'(used_in);
      end
   end

   assign stat.empty = (used_ff == '0);
   assign stat.full  = (used_ff == CNT_W'(NODES));
   assign stat.hit   = (key_q == key_ff);
   assign stat.tail  = ((step_ff + CNT_W'(1)) == used_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/linked_list_deque_with_key_delete.sv
// ----------------------------------------------------------------------------
// linked_list_deque_with_key_delete: bounded doubly linked key list
// Node pool with free stack; insert at front, delete by key or at either end,
// dump front to back.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the operation has finished its last memory access. Results come out one per
// rsp_valid pulse and cannot be stalled. Insert pops the free stack and then
// writes the node; delete first or last reads the end node and then unlinks
// it; a rejected or trivial item is answered at once. Delete by key reads and
// compares each node visited, then unlinks on a match, and dump reads and
// emits each key in turn, since each step of the walk is one registered read
// of the link memory. No clearing pass is needed after reset.
`default_nettype none

module linked_list_deque_with_key_delete #(
   parameter int NODES    = lldq_pkg::NODES_DEF,
   parameter int KEY_BITS = lldq_pkg::KEY_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic [lldq_pkg::FUNC_W-1:0]            req_func,
   input  wire logic signed [lldq_pkg::ITEM_KEY_W-1:0] req_item_key,
   output logic                                        rsp_valid,
   output logic signed [lldq_pkg::ITEM_KEY_W-1:0]      rsp_out_key,
   output logic [lldq_pkg::STATUS_W-1:0]               rsp_status,
   output logic                                        rsp_last_of_run,
   output logic [lldq_pkg::COUNT_W-1:0]                rsp_entry_count
);

   lldq_pkg::cmd_type  cmd;
   lldq_pkg::stat_type stat;

   // sequence each operation
   lldq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_func),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // hold the list and drive the results
   lldq_dp #(
      .NODES    (NODES),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_item_key    (req_item_key),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_out_key     (rsp_out_key),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_entry_count (rsp_entry_count)
   );

   // an accepted item either keeps the block busy or answers right away
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item produced neither work nor result");

   // the count never exceeds the pool
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= lldq_pkg::COUNT_W'(NODES)))
      else $error("entry count beyond pool size");

   // a dropped insert only happens on a full pool
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == lldq_pkg::STAT_FULL)
         |-> (rsp_entry_count == lldq_pkg::COUNT_W'(NODES)))
      else $error("insert dropped while pool not full");

   // a result that ends a run leaves the block ready
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> !busy)
      else $error("final result while still busy");

endmodule

`default_nettype wire

FILE: dv/tb_linked_list_deque_with_key_delete.sv
// ----------------------------------------------------------------------------
// tb_linked_list_deque_with_key_delete: self-checking bench for the key list
// Feeds a table of directed items and then random item sequences. A behavioral
// copy of the node pool predicts every result, and each rsp_valid pulse is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linked_list_deque_with_key_delete;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_NODES = lldq_pkg::NODES_DEF;

   typedef struct {
      logic signed [lldq_pkg::ITEM_KEY_W-1:0] out_key;
      lldq_pkg::status_type                   status;
      logic                                   last_of_run;
      logic [lldq_pkg::COUNT_W-1:0]           entry_count;
   } list_result_type;

   // One directed row: item to send and, optionally, the one result it gives.
   typedef struct {
      logic [lldq_pkg::FUNC_W-1:0]            func;
      logic signed [lldq_pkg::ITEM_KEY_W-1:0] item_key;
      bit                                     typed;
      lldq_pkg::status_type                   status;
      logic [lldq_pkg::COUNT_W-1:0]           entry_count;
   } list_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   start = 1'b0;
   logic                                   busy;
   logic [lldq_pkg::FUNC_W-1:0]            req_func = '0;
   logic signed [lldq_pkg::ITEM_KEY_W-1:0] req_item_key = '0;
   logic                                   rsp_valid;
   logic signed [lldq_pkg::ITEM_KEY_W-1:0] rsp_out_key;
   logic [lldq_pkg::STATUS_W-1:0]          rsp_status;
   logic                                   rsp_last_of_run;
   logic [lldq_pkg::COUNT_W-1:0]           rsp_entry_count;

   // Predictor state: the list is held as a front-to-back queue of keys.
   // Node indices do not show at the ports, so keys alone suffice.
   logic signed [lldq_pkg::ITEM_KEY_W-1:0] list_keys[$];
   list_result_type                        pending_results[$];
   int                                     error_count = 0;
   int                                     sender_idle_pct = 22;

   linked_list_deque_with_key_delete dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_item_key    (req_item_key),
      .rsp_valid       (rsp_valid),
      .rsp_out_key     (rsp_out_key),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Queue one status result with the list size after the operation.
   function automatic void push_status(lldq_pkg::status_type st);
      list_result_type r;
      r.out_key     = '0;
      r.status      = st;
      r.last_of_run = 1'b1;
      r.entry_count = lldq_pkg::COUNT_W'(list_keys.size());
      pending_results.push_back(r);
   endfunction

   // Apply one item to the list copy and queue the results it causes.
   function automatic void predict_list_op(logic [lldq_pkg::FUNC_W-1:0] f,
                                           logic signed [lldq_pkg::ITEM_KEY_W-1:0] k);
      list_result_type r;
      bit              found;
      found = 1'b0;
      case (f)
         lldq_pkg::FUNC_INSERT: begin
            if (list_keys.size() >= NUM_NODES) begin
               push_status(lldq_pkg::STAT_FULL);
            end else begin
               list_keys.push_front(k);
               push_status(lldq_pkg::STAT_DONE);
            end
         end
         lldq_pkg::FUNC_DEL_KEY: begin
            // unlink the first match from the front
            for (int i = 0; i < list_keys.size(); i++) begin
               if (list_keys[i] == k) begin
                  list_keys.delete(i);
                  found = 1'b1;
                  break;
               end
            end
            push_status(found ? lldq_pkg::STAT_DONE : lldq_pkg::STAT_MISS);
         end
         lldq_pkg::FUNC_DEL_FIRST, lldq_pkg::FUNC_DEL_LAST: begin
            if (list_keys.size() == 0) begin
               push_status(lldq_pkg::STAT_MISS);
            end else begin
               if (f == lldq_pkg::FUNC_DEL_FIRST) void'(list_keys.pop_front());
               else void'(list_keys.pop_back());
               push_status(lldq_pkg::STAT_DONE);
            end
         end
         lldq_pkg::FUNC_DUMP: begin
            if (list_keys.size() == 0) begin
               push_status(lldq_pkg::STAT_MISS);
            end else begin
               foreach (list_keys[i]) begin
                  r.out_key     = list_keys[i];
                  r.status      = lldq_pkg::STAT_ENTRY;
                  r.last_of_run = (i == list_keys.size() - 1);
                  r.entry_count = lldq_pkg::COUNT_W'(list_keys.size());
                  pending_results.push_back(r);
               end
            end
         end
         default: begin
            // unused codes are ignored but still answered
            push_status(lldq_pkg::STAT_MISS);
         end
      endcase
   endfunction

   // Check every result pulse at the rising edge against the oldest prediction.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: out_key %0d status %0d", rsp_out_key, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_key !== want.out_key) begin
               $error("out_key: expected %0d, got %0d", want.out_key, rsp_out_key);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b",
                      want.last_of_run, rsp_last_of_run);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // Drive one item at the falling edge and hold it until taken. Start is
   // dropped only when idle cycles precede the item, so that items can also
   // follow back to back. Returns at the falling edge after the accept.
   task automatic send_item(logic [lldq_pkg::FUNC_W-1:0] f,
                            logic signed [lldq_pkg::ITEM_KEY_W-1:0] k);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      end
      start        <= 1'b1;
      req_func     <= f;
      req_item_key <= k;
      do @(posedge clock); while (busy);
      predict_list_op(f, k);
      @(negedge clock);
   endtask

   // Drop start and hold off until every expected result has arrived.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Pick a key: mostly from a small pool so deletes hit, sometimes extremes.
   function automatic logic signed [lldq_pkg::ITEM_KEY_W-1:0] pick_key();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3: return $urandom();
         default: return $urandom_range(15) - 8;
      endcase
   endfunction

   function automatic list_row_type row(logic [lldq_pkg::FUNC_W-1:0] f,
                                        logic signed [lldq_pkg::ITEM_KEY_W-1:0] k,
                                        bit typed = 1'b0,
                                        lldq_pkg::status_type st = lldq_pkg::STAT_DONE,
                                        logic [lldq_pkg::COUNT_W-1:0] cnt = '0);
      list_row_type r;
      r.func = f; r.item_key = k; r.typed = typed;
      r.status = st; r.entry_count = cnt;
      return r;
   endfunction

   initial begin
      list_row_type    dir_rows[$];
      list_result_type probe;
      int              phase, n, fill;
      logic [lldq_pkg::FUNC_W-1:0] f;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-list cases, extremes, every op, unused codes.
      dir_rows.push_back(row(lldq_pkg::FUNC_DUMP,      0, 1, lldq_pkg::STAT_MISS, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_FIRST, 0, 1, lldq_pkg::STAT_MISS, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_LAST,  0, 1, lldq_pkg::STAT_MISS, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_KEY,   5, 1, lldq_pkg::STAT_MISS, 0));
      dir_rows.push_back(row(3'd5,  0, 1, lldq_pkg::STAT_MISS, 0));
      dir_rows.push_back(row(3'd6, -1, 1, lldq_pkg::STAT_MISS, 0));
      dir_rows.push_back(row(3'd7,  0, 1, lldq_pkg::STAT_MISS, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_INSERT, 32'sh8000_0000, 1,
                             lldq_pkg::STAT_DONE, 1));
      dir_rows.push_back(row(lldq_pkg::FUNC_INSERT, 32'sh7fff_ffff, 1,
                             lldq_pkg::STAT_DONE, 2));
      dir_rows.push_back(row(lldq_pkg::FUNC_INSERT, -1, 1, lldq_pkg::STAT_DONE, 3));
      dir_rows.push_back(row(lldq_pkg::FUNC_INSERT,  0, 1, lldq_pkg::STAT_DONE, 4));
      dir_rows.push_back(row(lldq_pkg::FUNC_INSERT, -1));
      dir_rows.push_back(row(lldq_pkg::FUNC_DUMP, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_KEY, -1));   // first of two duplicates
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_KEY, 12345, 1, lldq_pkg::STAT_MISS, 4));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_KEY, 32'sh8000_0000)); // key at the back
      dir_rows.push_back(row(lldq_pkg::FUNC_DUMP, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_FIRST, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_LAST, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DUMP, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DEL_FIRST, 0, 1, lldq_pkg::STAT_DONE, 0));
      dir_rows.push_back(row(lldq_pkg::FUNC_DUMP, 0, 1, lldq_pkg::STAT_MISS, 0));
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].func, dir_rows[i].item_key);
         // typed-in rows cross-check the predictor's own answer
         if (dir_rows[i].typed) begin
            probe = pending_results[$];
            if (probe.status !== dir_rows[i].status) begin
               $error("status: expected %0d, got %0d", dir_rows[i].status, probe.status);
               error_count++;
            end
            if (probe.entry_count !== dir_rows[i].entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      dir_rows[i].entry_count, probe.entry_count);
               error_count++;
            end
         end
      end

      // Hold off until every result has arrived.
      wait_drained();

      // Fill the pool to overflow, dump it full, then drain half from both ends.
      for (fill = 0; fill < NUM_NODES + 2; fill++)
         send_item(lldq_pkg::FUNC_INSERT, pick_key());
      send_item(lldq_pkg::FUNC_DUMP, 0);
      while (list_keys.size() > NUM_NODES / 2)
         send_item($urandom_range(1) ? lldq_pkg::FUNC_DEL_FIRST : lldq_pkg::FUNC_DEL_LAST,
                   0);

      // Random: three idle phases, biased toward insert so the list grows.
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 57 : 0;
         for (n = 0; n < 12; n++) begin
            case ($urandom_range(19))
               0, 1, 2, 3, 4, 5, 6, 7: f = lldq_pkg::FUNC_INSERT;
               8, 9, 10, 11:           f = lldq_pkg::FUNC_DEL_KEY;
               12, 13:                 f = lldq_pkg::FUNC_DEL_FIRST;
               14, 15:                 f = lldq_pkg::FUNC_DEL_LAST;
               16, 17, 18:             f = lldq_pkg::FUNC_DUMP;
               default:                f = 3'($urandom_range(7, 5));
            endcase
            // search for a stored key most of the time
            if (f == lldq_pkg::FUNC_DEL_KEY && list_keys.size() > 0 &&
                $urandom_range(3) != 0)
               send_item(f, list_keys[$urandom_range(list_keys.size() - 1)]);
            else
               send_item(f, pick_key());
         end
      end

      wait_drained();
      repeat (2 * NUM_NODES + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
